@@ src/smsdp_pkg.sv @@
// Shared types, codes and constants of the SMS-DELIVER PDU parser.
`default_nettype none

package smsdp_pkg;

  localparam int unsigned MIN_PDU_BYTES = 14;
  localparam int unsigned MAX_ITEMS = 6;
  localparam int unsigned ITEM_IDX_W = $clog2(MAX_ITEMS + 1);

  // token kinds
  localparam logic [3:0] K_SMSC_DIGIT  = 4'd0;
  localparam logic [3:0] K_SMSC_PLUS   = 4'd1;
  localparam logic [3:0] K_SMSC_ALPHA  = 4'd2;
  localparam logic [3:0] K_SND_DIGIT   = 4'd3;
  localparam logic [3:0] K_SND_PLUS    = 4'd4;
  localparam logic [3:0] K_SND_ALPHA   = 4'd5;
  localparam logic [3:0] K_TIME_DIGIT  = 4'd6;
  localparam logic [3:0] K_TIMEZONE    = 4'd7;
  localparam logic [3:0] K_CODING      = 4'd8;
  localparam logic [3:0] K_REFERENCE   = 4'd9;
  localparam logic [3:0] K_COUNT       = 4'd10;
  localparam logic [3:0] K_SEQUENCE    = 4'd11;
  localparam logic [3:0] K_USER_OCTET  = 4'd12;
  localparam logic [3:0] K_DONE        = 4'd13;
  localparam logic [3:0] K_ERROR       = 4'd14;

  // error codes
  localparam logic [2:0] E_TOO_SHORT   = 3'd1;
  localparam logic [2:0] E_TRUNC_SMSC  = 3'd2;
  localparam logic [2:0] E_NOT_DELIVER = 3'd3;
  localparam logic [2:0] E_TRUNC_SND   = 3'd4;
  localparam logic [2:0] E_TRUNC_TIME  = 3'd5;
  localparam logic [2:0] E_TRUNC_UDH   = 3'd6;
  localparam logic [2:0] E_TRUNC_UD    = 3'd7;

  // coding schemes
  localparam logic [1:0] SCH_GSM7 = 2'd0;
  localparam logic [1:0] SCH_UCS2 = 2'd1;
  localparam logic [1:0] SCH_8BIT = 2'd2;

  typedef enum logic [16:0] {
    PH_SMSC_LEN  = 17'h00001,
    PH_SMSC_TYPE = 17'h00002,
    PH_SMSC_ADDR = 17'h00004,
    PH_FLAGS     = 17'h00008,
    PH_SND_LEN   = 17'h00010,
    PH_SND_TYPE  = 17'h00020,
    PH_SND_ADDR  = 17'h00040,
    PH_PROTO     = 17'h00080,
    PH_CODING    = 17'h00100,
    PH_TIME      = 17'h00200,
    PH_UDL       = 17'h00400,
    PH_UDHL      = 17'h00800,
    PH_EL_ID     = 17'h01000,
    PH_EL_LEN    = 17'h02000,
    PH_EL_DATA   = 17'h04000,
    PH_TEXT      = 17'h08000,
    PH_TRAIL     = 17'h10000
  } phase_t;

  typedef struct packed {
    logic [3:0]  kind;
    logic [15:0] value;
    logic [2:0]  aux;
  } item_t;

  typedef struct packed {
    phase_t      phase;
    logic [7:0]  seen;
    logic [7:0]  rem;
    logic [7:0]  atype;
    logic [7:0]  flags;
    logic [7:0]  coding;
    logic [7:0]  ulen;
    logic [8:0]  hlen;
    logic [7:0]  el_id;
    logic [7:0]  el_rem;
    logic [15:0] cref;
    logic [15:0] ccs;
    logic [2:0]  err;
    logic        errl;
  } state_t;

  localparam state_t STATE_RESET = '{
    phase: PH_SMSC_LEN, seen: 8'd0, rem: 8'd0, atype: 8'd0, flags: 8'd0,
    coding: 8'd0, ulen: 8'd0, hlen: 9'd0, el_id: 8'd0, el_rem: 8'd0,
    cref: 16'd0, ccs: 16'h0101, err: 3'd0, errl: 1'b0
  };

endpackage

`default_nettype wire

@@ src/smsdp_if.sv @@
// Valid/ready channel interfaces for PDU octets and parsed tokens.
`default_nettype none

interface smsdp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] pdu_byte;
  logic       pdu_end;
  modport source (output valid, pdu_byte, pdu_end, input ready);
  modport sink (input valid, pdu_byte, pdu_end, output ready);
endinterface

interface smsdp_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  item_kind;
  logic [15:0] item_value;
  logic [2:0]  item_aux;
  logic        item_last;
  modport source (output valid, item_kind, item_value, item_aux, item_last, input ready);
  modport sink (input valid, item_kind, item_value, item_aux, item_last, output ready);
endinterface

`default_nettype wire

@@ src/sms_deliver_pdu_parser.sv @@
// SMS-DELIVER PDU parser top level: state register, token buffer and handshakes.
// Takes one PDU octet per beat and returns the tokens it causes, up to six per octet
// (address and timestamp digits, coding, concatenation fields, user octets,
// and done or an error code on the octet marked last; earlier tokens count only if
// done follows). An octet is parsed in the cycle it is accepted and its tokens are
// loaded into a six-entry buffer; the buffer then hands out one token per cycle
// while the sink is ready. The next octet is accepted in the cycle the last token
// of the previous one is taken.
`default_nettype none

module sms_deliver_pdu_parser #(
  parameter int unsigned MIN_PDU_BYTES = smsdp_pkg::MIN_PDU_BYTES
) (
  input wire logic     clk,
  input wire logic     rst,
  smsdp_in_if.sink     pdu_in,
  smsdp_out_if.source  item_out
);

  localparam int unsigned IW = smsdp_pkg::ITEM_IDX_W;

  smsdp_pkg::state_t st;
  smsdp_pkg::state_t st_next;
  smsdp_pkg::item_t  step_res [smsdp_pkg::MAX_ITEMS];
  logic [IW-1:0]     step_n;
  smsdp_pkg::item_t  tok [smsdp_pkg::MAX_ITEMS];
  logic [IW-1:0]     tok_n;
  logic [IW-1:0]     tok_i;
  logic              take;
  logic              last;
  logic              accept;

  smsdp_step #(.MIN_PDU_BYTES(MIN_PDU_BYTES)) u_step (
    .st       (st),
    .pdu_byte (pdu_in.pdu_byte),
    .pdu_end  (pdu_in.pdu_end),
    .st_next  (st_next),
    .res      (step_res),
    .res_n    (step_n)
  );

  // drive the token side from the buffer
  assign last                = (tok_i == tok_n - 1'b1);
  assign item_out.valid      = (tok_n != '0);
  assign item_out.item_kind  = tok[tok_i].kind;
  assign item_out.item_value = tok[tok_i].value;
  assign item_out.item_aux   = tok[tok_i].aux;
  assign item_out.item_last  = last;
  assign take                = item_out.valid && item_out.ready;
  assign pdu_in.ready        = (tok_n == '0) || (take && last);
  assign accept              = pdu_in.valid && pdu_in.ready;

  // advance parse state and buffer control
  always_ff @(posedge clk) begin
    if (rst) begin
      st    <= smsdp_pkg::STATE_RESET;
      tok_n <= '0;
      tok_i <= '0;
    end else if (accept) begin
      st    <= st_next;
      tok_n <= step_n;
      tok_i <= '0;
    end else if (take) begin
      if (last) tok_n <= '0;
      else tok_i <= tok_i + 1'b1;
    end
  end

  // load token payloads
  always_ff @(posedge clk) begin
    if (accept) tok <= step_res;
  end

endmodule

`default_nettype wire

@@ src/smsdp_step.sv @@
// Per-octet parse step: next state and the token list for one PDU octet.
`default_nettype none

module smsdp_step #(
  parameter int unsigned MIN_PDU_BYTES = smsdp_pkg::MIN_PDU_BYTES
) (
  input  wire smsdp_pkg::state_t                st,
  input  wire logic [7:0]                       pdu_byte,
  input  wire logic                             pdu_end,
  output smsdp_pkg::state_t                     st_next,
  output smsdp_pkg::item_t                      res [smsdp_pkg::MAX_ITEMS],
  output logic [smsdp_pkg::ITEM_IDX_W-1:0]      res_n
);

  function automatic smsdp_pkg::item_t mk(input logic [3:0] k, input logic [15:0] v,
                                          input logic [2:0] a);
    smsdp_pkg::item_t it;
    it.kind = k;
    it.value = v;
    it.aux = a;
    return it;
  endfunction

  function automatic logic [1:0] scheme_of(input logic [7:0] c);
    logic [1:0] s;
    s = smsdp_pkg::SCH_GSM7;
    if (c[7:4] <= 4'd3) begin
      if (c[3:2] == 2'b10) s = smsdp_pkg::SCH_UCS2;
      else if (c[3:2] == 2'b01) s = smsdp_pkg::SCH_8BIT;
    end else if (c[7:4] == 4'hE) begin
      s = smsdp_pkg::SCH_UCS2;
    end else if (c[7:4] == 4'hF) begin
      s = c[2] ? smsdp_pkg::SCH_8BIT : smsdp_pkg::SCH_GSM7;
    end
    return s;
  endfunction

  // residue mod 7 by folding octal digits (8 = 1 mod 7)
  function automatic logic [2:0] mod7(input logic [8:0] h);
    logic [4:0] s1;
    logic [3:0] s2;
    s1 = 5'(h[2:0]) + 5'(h[5:3]) + 5'(h[8:6]);
    s2 = 4'(s1[2:0]) + 4'(s1[4:3]);
    return (s2 >= 4'd7) ? 3'(s2 - 4'd7) : s2[2:0];
  endfunction

  function automatic logic [2:0] trunc_code(input smsdp_pkg::phase_t p);
    logic [2:0] c;
    unique case (p)
      smsdp_pkg::PH_FLAGS, smsdp_pkg::PH_SND_LEN, smsdp_pkg::PH_SND_TYPE,
      smsdp_pkg::PH_SND_ADDR:                       c = smsdp_pkg::E_TRUNC_SND;
      smsdp_pkg::PH_PROTO, smsdp_pkg::PH_CODING,
      smsdp_pkg::PH_TIME:                           c = smsdp_pkg::E_TRUNC_TIME;
      smsdp_pkg::PH_UDL, smsdp_pkg::PH_UDHL, smsdp_pkg::PH_EL_ID,
      smsdp_pkg::PH_EL_LEN, smsdp_pkg::PH_EL_DATA:  c = smsdp_pkg::E_TRUNC_UDH;
      smsdp_pkg::PH_TEXT:                           c = smsdp_pkg::E_TRUNC_UD;
      default:                                      c = smsdp_pkg::E_TRUNC_SMSC;
    endcase
    return c;
  endfunction

  localparam int unsigned ITEM_W = smsdp_pkg::ITEM_IDX_W;

  smsdp_pkg::state_t s;
  logic [ITEM_W-1:0] n;
  logic        fin;
  logic        alpha;
  logic [3:0]  base;
  logic [1:0]  sch;
  logic [6:0]  qh;
  logic [10:0] t;
  logic [10:0] nt;
  logic [8:0]  half;
  logic [2:0]  r7;
  logic [2:0]  fill;

  always_comb begin
    s = st;
    n = '0;
    fin = 1'b0;
    for (int i = 0; i < smsdp_pkg::MAX_ITEMS; i++) res[i] = '0;
    alpha = (st.atype & 8'h70) == 8'h50;
    base = (st.phase == smsdp_pkg::PH_SMSC_ADDR) ? smsdp_pkg::K_SMSC_DIGIT
                                                 : smsdp_pkg::K_SND_DIGIT;
    qh = 7'(pdu_byte[2:0]) * 7'd10 + 7'(pdu_byte[7:4]);
    half = (9'(pdu_byte) + 9'd1) >> 1;
    sch = '0;
    t = '0;
    nt = '0;
    r7 = '0;
    fill = '0;

    if (s.seen != 8'hFF) s.seen = s.seen + 8'd1;

    // parse the octet
    if (!s.errl) begin
      unique case (st.phase)
        smsdp_pkg::PH_SMSC_LEN: begin
          if (pdu_byte == 8'd0) s.phase = smsdp_pkg::PH_FLAGS;
          else begin
            s.rem = pdu_byte - 8'd1;
            s.phase = smsdp_pkg::PH_SMSC_TYPE;
          end
        end
        smsdp_pkg::PH_SMSC_TYPE, smsdp_pkg::PH_SND_TYPE: begin
          s.atype = pdu_byte;
          if ((pdu_byte & 8'h70) == 8'h10) begin
            res[n] = mk((st.phase == smsdp_pkg::PH_SMSC_TYPE) ? smsdp_pkg::K_SMSC_PLUS
                                                               : smsdp_pkg::K_SND_PLUS,
                        16'd0, 3'd0);
            n = n + 1'b1;
          end
          if (st.phase == smsdp_pkg::PH_SMSC_TYPE)
            s.phase = (s.rem != 0) ? smsdp_pkg::PH_SMSC_ADDR : smsdp_pkg::PH_FLAGS;
          else
            s.phase = (s.rem != 0) ? smsdp_pkg::PH_SND_ADDR : smsdp_pkg::PH_PROTO;
        end
        smsdp_pkg::PH_SMSC_ADDR, smsdp_pkg::PH_SND_ADDR: begin
          if (alpha) begin
            res[n] = mk(base + 4'd2, 16'(pdu_byte), 3'd0);
            n = n + 1'b1;
          end else begin
            if (pdu_byte[3:0] != 4'hF) begin
              res[n] = mk(base, 16'(pdu_byte[3:0]), 3'd0);
              n = n + 1'b1;
            end
            if (pdu_byte[7:4] != 4'hF) begin
              res[n] = mk(base, 16'(pdu_byte[7:4]), 3'd0);
              n = n + 1'b1;
            end
          end
          s.rem = s.rem - 8'd1;
          if (s.rem == 0)
            s.phase = (st.phase == smsdp_pkg::PH_SMSC_ADDR) ? smsdp_pkg::PH_FLAGS
                                                            : smsdp_pkg::PH_PROTO;
        end
        smsdp_pkg::PH_FLAGS: begin
          s.flags = pdu_byte;
          if (pdu_byte[1:0] != 2'b00) begin
            s.errl = 1'b1;
            s.err = smsdp_pkg::E_NOT_DELIVER;
          end else begin
            s.phase = smsdp_pkg::PH_SND_LEN;
          end
        end
        smsdp_pkg::PH_SND_LEN: begin
          s.rem = half[7:0];
          s.phase = smsdp_pkg::PH_SND_TYPE;
        end
        smsdp_pkg::PH_PROTO: s.phase = smsdp_pkg::PH_CODING;
        smsdp_pkg::PH_CODING: begin
          s.coding = pdu_byte;
          s.rem = 8'd7;
          s.phase = smsdp_pkg::PH_TIME;
        end
        smsdp_pkg::PH_TIME: begin
          if (s.rem > 8'd1) begin
            if (pdu_byte[3:0] != 4'hF) begin
              res[n] = mk(smsdp_pkg::K_TIME_DIGIT, 16'(pdu_byte[3:0]), 3'd0);
              n = n + 1'b1;
            end
            if (pdu_byte[7:4] != 4'hF) begin
              res[n] = mk(smsdp_pkg::K_TIME_DIGIT, 16'(pdu_byte[7:4]), 3'd0);
              n = n + 1'b1;
            end
            s.rem = s.rem - 8'd1;
          end else begin
            res[n] = mk(smsdp_pkg::K_TIMEZONE, 16'(qh[6:2]), {2'b00, pdu_byte[3]});
            n = n + 1'b1;
            s.rem = 8'd0;
            s.phase = smsdp_pkg::PH_UDL;
          end
        end
        smsdp_pkg::PH_UDL: begin
          s.ulen = pdu_byte;
          if (s.flags[6]) s.phase = smsdp_pkg::PH_UDHL;
          else begin
            s.hlen = 9'd0;
            res[n] = mk(smsdp_pkg::K_CODING, 16'(scheme_of(s.coding)), 3'd0);
            n = n + 1'b1;
            fin = 1'b1;
          end
        end
        smsdp_pkg::PH_UDHL: begin
          s.hlen = 9'(pdu_byte) + 9'd1;
          sch = scheme_of(s.coding);
          // fill bits pad the header out to a septet boundary
          r7 = mod7(s.hlen);
          fill = (sch == smsdp_pkg::SCH_GSM7 && r7 != 3'd0) ? 3'd7 - r7 : 3'd0;
          res[n] = mk(smsdp_pkg::K_CODING, 16'(sch), fill);
          n = n + 1'b1;
          s.rem = pdu_byte;
          if (pdu_byte == 8'd0) fin = 1'b1;
          else s.phase = smsdp_pkg::PH_EL_ID;
        end
        smsdp_pkg::PH_EL_ID: begin
          s.el_id = pdu_byte;
          s.phase = smsdp_pkg::PH_EL_LEN;
          s.rem = s.rem - 8'd1;
          fin = (s.rem == 0);
        end
        smsdp_pkg::PH_EL_LEN: begin
          if (!((s.el_id == 8'h00 && pdu_byte == 8'd3) ||
                (s.el_id == 8'h08 && pdu_byte == 8'd4)))
            s.el_id = 8'hFF;
          s.el_rem = pdu_byte;
          s.phase = (pdu_byte == 8'd0) ? smsdp_pkg::PH_EL_ID : smsdp_pkg::PH_EL_DATA;
          s.rem = s.rem - 8'd1;
          fin = (s.rem == 0);
        end
        smsdp_pkg::PH_EL_DATA: begin
          if (s.el_id == 8'h00 || s.el_id == 8'h08) begin
            if (s.el_rem == 8'd4) s.cref = {pdu_byte, 8'h00};
            else if (s.el_rem == 8'd3) begin
              if (s.el_id == 8'h00) s.cref = {8'h00, pdu_byte};
              else s.cref = s.cref | {8'h00, pdu_byte};
            end else if (s.el_rem == 8'd2) s.ccs[15:8] = pdu_byte;
            else if (s.el_rem == 8'd1) s.ccs[7:0] = pdu_byte;
          end
          s.el_rem = s.el_rem - 8'd1;
          if (s.el_rem == 0) s.phase = smsdp_pkg::PH_EL_ID;
          s.rem = s.rem - 8'd1;
          fin = (s.rem == 0);
        end
        smsdp_pkg::PH_TEXT: begin
          res[n] = mk(smsdp_pkg::K_USER_OCTET, 16'(pdu_byte), 3'd0);
          n = n + 1'b1;
          s.rem = s.rem - 8'd1;
          if (s.rem == 0) s.phase = smsdp_pkg::PH_TRAIL;
        end
        default: ;
      endcase
    end

    // close the header: concatenation tokens and user data extent
    if (fin) begin
      res[n] = mk(smsdp_pkg::K_REFERENCE, s.cref, 3'd0);
      n = n + 1'b1;
      res[n] = mk(smsdp_pkg::K_COUNT, 16'(s.ccs[15:8]), 3'd0);
      n = n + 1'b1;
      res[n] = mk(smsdp_pkg::K_SEQUENCE, 16'(s.ccs[7:0]), 3'd0);
      n = n + 1'b1;
      if (scheme_of(s.coding) == smsdp_pkg::SCH_GSM7)
        t = ({3'b000, s.ulen} * 11'd7 + 11'd7) >> 3;
      else
        t = 11'(s.ulen);
      nt = (t > 11'(s.hlen)) ? (t - 11'(s.hlen)) : 11'd0;
      if (nt == 0) s.phase = smsdp_pkg::PH_TRAIL;
      else begin
        s.rem = nt[7:0];
        s.phase = smsdp_pkg::PH_TEXT;
      end
    end

    // final octet: done or error, then back to reset
    if (pdu_end) begin
      if (s.seen < 8'(MIN_PDU_BYTES)) begin
        res[n] = mk(smsdp_pkg::K_ERROR, 16'(smsdp_pkg::E_TOO_SHORT), 3'd0);
        n = n + 1'b1;
      end else if (s.errl) begin
        res[n] = mk(smsdp_pkg::K_ERROR, 16'(s.err), 3'd0);
        n = n + 1'b1;
      end else begin
        // end right after the timestamp: user data length taken as zero
        if (s.phase == smsdp_pkg::PH_UDL) begin
          if (s.flags[6]) s.phase = smsdp_pkg::PH_UDHL;
          else begin
            res[n] = mk(smsdp_pkg::K_CODING, 16'(scheme_of(s.coding)), 3'd0);
            n = n + 1'b1;
            res[n] = mk(smsdp_pkg::K_REFERENCE, s.cref, 3'd0);
            n = n + 1'b1;
            res[n] = mk(smsdp_pkg::K_COUNT, 16'(s.ccs[15:8]), 3'd0);
            n = n + 1'b1;
            res[n] = mk(smsdp_pkg::K_SEQUENCE, 16'(s.ccs[7:0]), 3'd0);
            n = n + 1'b1;
            s.phase = smsdp_pkg::PH_TRAIL;
          end
        end
        if (s.phase == smsdp_pkg::PH_TRAIL)
          res[n] = mk(smsdp_pkg::K_DONE, 16'd0, 3'd0);
        else
          res[n] = mk(smsdp_pkg::K_ERROR, 16'(trunc_code(s.phase)), 3'd0);
        n = n + 1'b1;
      end
      s = smsdp_pkg::STATE_RESET;
    end

    st_next = s;
    res_n = n;
  end

endmodule

`default_nettype wire

@@ src/smsdp_chk.sv @@
// Port checker for the SMS-DELIVER PDU parser, bound to the top level.
`default_nettype none

module smsdp_chk (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [3:0]  out_kind,
  input wire logic [15:0] out_value,
  input wire logic [2:0]  out_aux,
  input wire logic        out_last
);

  // hold a stalled token
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_value))
    else $error("stalled token changed");

  // take no octet while tokens of the previous one remain
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |-> !out_valid || (out_ready && out_last))
    else $error("octet accepted over pending tokens");

  // done and error close the octet's token list
  a_final_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_kind == smsdp_pkg::K_DONE || out_kind == smsdp_pkg::K_ERROR)
      |-> out_last)
    else $error("final token not last");

  // aux only on timezone and coding tokens
  a_aux: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_aux != 3'd0
      |-> out_kind == smsdp_pkg::K_TIMEZONE || out_kind == smsdp_pkg::K_CODING)
    else $error("aux set on wrong token");

endmodule

bind sms_deliver_pdu_parser smsdp_chk u_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (pdu_in.valid),
  .in_ready  (pdu_in.ready),
  .out_valid (item_out.valid),
  .out_ready (item_out.ready),
  .out_kind  (item_out.item_kind),
  .out_value (item_out.item_value),
  .out_aux   (item_out.item_aux),
  .out_last  (item_out.item_last)
);

`default_nettype wire

@@ test/sms_deliver_pdu_parser_checker.sv @@
// Token predictor and scoreboard for the SMS-DELIVER PDU parser.
`timescale 1ns / 100ps
`default_nettype none

module sms_deliver_pdu_parser_checker
  import smsdp_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  smsdp_in_if      pdu_in,
  smsdp_out_if     item_out,
  output int       fail_count,
  output int       tokens_pending
);

  typedef struct packed {
    logic [3:0]  kind;
    logic [15:0] value;
    logic [2:0]  aux;
    logic        last;
  } token_t;

  token_t token_queue[$];

  phase_t      phase;
  logic [7:0]  seen, rem, atype, flags, coding, ulen, el_id, el_rem;
  logic [8:0]  hlen;
  logic [15:0] cref, ccs;
  logic [2:0]  err;
  logic        errl;
  token_t      pending[$];

  assign tokens_pending = token_queue.size();

  function automatic void clear_state();
    phase = PH_SMSC_LEN; seen = 0; rem = 0; atype = 0; flags = 0; coding = 0;
    ulen = 0; hlen = 0; el_id = 0; el_rem = 0; cref = 0; ccs = 16'h0101;
    err = 0; errl = 0;
  endfunction

  function automatic void push_token(logic [3:0] k, logic [15:0] v, logic [2:0] a);
    token_t t;
    t.kind = k; t.value = v; t.aux = a; t.last = 1'b0;
    if (pending.size() < MAX_ITEMS) pending = {pending, t};
  endfunction

  function automatic logic [1:0] scheme();
    logic [3:0] hi;
    hi = coding[7:4];
    if (hi <= 3) begin
      if (coding[3:2] == 2'b10) return SCH_UCS2;
      if (coding[3:2] == 2'b01) return SCH_8BIT;
      return SCH_GSM7;
    end
    if (hi == 4'hE) return SCH_UCS2;
    if (hi == 4'hF) return coding[2] ? SCH_8BIT : SCH_GSM7;
    return SCH_GSM7;
  endfunction

  function automatic logic [2:0] fill();
    int adj;
    if (scheme() != SCH_GSM7 || hlen == 0) return 0;
    adj = (hlen * 8 + 6) / 7;
    return 3'(adj * 7 - hlen * 8);
  endfunction

  function automatic void close_header();
    int t;
    push_token(K_REFERENCE, cref, 0);
    push_token(K_COUNT, ccs[15:8], 0);
    push_token(K_SEQUENCE, ccs[7:0], 0);
    t = (scheme() == SCH_GSM7) ? (ulen * 7 + 7) / 8 : ulen;
    t = (t > hlen) ? t - hlen : 0;
    if (t == 0) phase = PH_TRAIL;
    else begin
      rem = 8'(t);
      phase = PH_TEXT;
    end
  endfunction

  function automatic void digits(logic [3:0] k, logic [7:0] b);
    if (b[3:0] != 4'hF) push_token(k, b[3:0], 0);
    if (b[7:4] != 4'hF) push_token(k, b[7:4], 0);
  endfunction

  function automatic void address_octet(logic [3:0] k, logic [7:0] b);
    if ((atype & 8'h70) == 8'h50) push_token(k + 4'd2, b, 0);
    else digits(k, b);
  endfunction

  function automatic void header_octet_done();
    rem--;
    if (rem == 0) close_header();
  endfunction

  function automatic void parse_octet(logic [7:0] b);
    int qh;
    case (phase)
      PH_SMSC_LEN: begin
        if (b == 0) phase = PH_FLAGS;
        else begin
          rem = b - 8'd1;
          phase = PH_SMSC_TYPE;
        end
      end
      PH_SMSC_TYPE: begin
        atype = b;
        if ((b & 8'h70) == 8'h10) push_token(K_SMSC_PLUS, 0, 0);
        phase = (rem != 0) ? PH_SMSC_ADDR : PH_FLAGS;
      end
      PH_SMSC_ADDR: begin
        address_octet(K_SMSC_DIGIT, b);
        rem--;
        if (rem == 0) phase = PH_FLAGS;
      end
      PH_FLAGS: begin
        flags = b;
        if (b[1:0] != 0) begin
          errl = 1;
          err = E_NOT_DELIVER;
        end else phase = PH_SND_LEN;
      end
      PH_SND_LEN: begin
        rem = 8'((9'(b) + 9'd1) >> 1);
        phase = PH_SND_TYPE;
      end
      PH_SND_TYPE: begin
        atype = b;
        if ((b & 8'h70) == 8'h10) push_token(K_SND_PLUS, 0, 0);
        phase = (rem != 0) ? PH_SND_ADDR : PH_PROTO;
      end
      PH_SND_ADDR: begin
        address_octet(K_SND_DIGIT, b);
        rem--;
        if (rem == 0) phase = PH_PROTO;
      end
      PH_PROTO: phase = PH_CODING;
      PH_CODING: begin
        coding = b;
        rem = 7;
        phase = PH_TIME;
      end
      PH_TIME: begin
        if (rem > 1) begin
          digits(K_TIME_DIGIT, b);
          rem--;
        end else begin
          qh = b[2:0] * 10 + b[7:4];
          push_token(K_TIMEZONE, 16'(qh / 4), {2'b0, b[3]});
          rem = 0;
          phase = PH_UDL;
        end
      end
      PH_UDL: begin
        ulen = b;
        if (flags[6]) phase = PH_UDHL;
        else begin
          hlen = 0;
          push_token(K_CODING, scheme(), 0);
          close_header();
        end
      end
      PH_UDHL: begin
        hlen = 9'(b) + 9'd1;
        push_token(K_CODING, scheme(), fill());
        rem = b;
        if (b == 0) close_header();
        else phase = PH_EL_ID;
      end
      PH_EL_ID: begin
        el_id = b;
        phase = PH_EL_LEN;
        header_octet_done();
      end
      PH_EL_LEN: begin
        if (!((el_id == 8'h00 && b == 3) || (el_id == 8'h08 && b == 4))) el_id = 8'hFF;
        el_rem = b;
        phase = (b == 0) ? PH_EL_ID : PH_EL_DATA;
        header_octet_done();
      end
      PH_EL_DATA: begin
        if (el_id == 8'h00 || el_id == 8'h08) begin
          case (el_rem)
            8'd4: cref = {b, 8'h00};
            8'd3: cref = (el_id == 8'h00) ? {8'h00, b} : (cref | {8'h00, b});
            8'd2: ccs[15:8] = b;
            8'd1: ccs[7:0] = b;
            default: ;
          endcase
        end
        el_rem--;
        if (el_rem == 0) phase = PH_EL_ID;
        header_octet_done();
      end
      PH_TEXT: begin
        push_token(K_USER_OCTET, b, 0);
        rem--;
        if (rem == 0) phase = PH_TRAIL;
      end
      default: ;
    endcase
  endfunction

  function automatic logic [2:0] truncation();
    case (phase)
      PH_FLAGS, PH_SND_LEN, PH_SND_TYPE, PH_SND_ADDR: return E_TRUNC_SND;
      PH_PROTO, PH_CODING, PH_TIME: return E_TRUNC_TIME;
      PH_UDL, PH_UDHL, PH_EL_ID, PH_EL_LEN, PH_EL_DATA: return E_TRUNC_UDH;
      PH_TEXT: return E_TRUNC_UD;
      default: return E_TRUNC_SMSC;
    endcase
  endfunction

  // Predict the tokens of one accepted octet
  function automatic void predict_octet(logic [7:0] b, logic last_octet);
    pending.delete();
    if (seen != 8'hFF) seen++;
    if (!errl) parse_octet(b);
    if (last_octet) begin
      if (seen < MIN_PDU_BYTES) push_token(K_ERROR, E_TOO_SHORT, 0);
      else if (errl) push_token(K_ERROR, err, 0);
      else begin
        if (phase == PH_UDL) parse_octet(8'h00);
        if (phase == PH_TRAIL) push_token(K_DONE, 0, 0);
        else push_token(K_ERROR, truncation(), 0);
      end
      clear_state();
    end
    if (pending.size() > 0) pending[pending.size() - 1].last = 1'b1;
    foreach (pending[i]) token_queue = {token_queue, pending[i]};
  endfunction

  // Predict on input beats, compare on output beats
  always @(posedge clk) begin
    token_t exp_t;
    if (rst) begin
      clear_state();
      token_queue.delete();
      fail_count <= 0;
    end else begin
      if (item_out.valid && item_out.ready) begin
        if (token_queue.size() == 0) begin
          $display("%0t: unexpected token kind %0d value %0d aux %0d last %0d", $time,
                   item_out.item_kind, item_out.item_value, item_out.item_aux,
                   item_out.item_last);
          fail_count <= fail_count + 1;
        end else begin
          exp_t = token_queue.pop_front();
          if (exp_t != {item_out.item_kind, item_out.item_value, item_out.item_aux,
                        item_out.item_last}) begin
            $display("%0t: token mismatch: expected kind %0d value %0d aux %0d last %0d,",
                     $time, exp_t.kind, exp_t.value, exp_t.aux, exp_t.last,
                     " actual kind %0d value %0d aux %0d last %0d", item_out.item_kind,
                     item_out.item_value, item_out.item_aux, item_out.item_last);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (pdu_in.valid && pdu_in.ready) predict_octet(pdu_in.pdu_byte, pdu_in.pdu_end);
    end
  end

endmodule

`default_nettype wire

@@ test/sms_deliver_pdu_parser_test.sv @@
// Stimulus and verdict for the SMS-DELIVER PDU parser.
`timescale 1ns / 100ps
`default_nettype none

module sms_deliver_pdu_parser_test;
  import smsdp_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fail_count;
  int   tokens_pending;
  int   octets_sent = 0;
  logic stall_sink = 1'b0;

  smsdp_in_if  pdu_in();
  smsdp_out_if item_out();

  sms_deliver_pdu_parser DUT (
    .clk(clk), .rst(rst), .pdu_in(pdu_in), .item_out(item_out)
  );

  sms_deliver_pdu_parser_checker checker_inst (
    .clk(clk), .rst(rst), .pdu_in(pdu_in), .item_out(item_out),
    .fail_count(fail_count), .tokens_pending(tokens_pending)
  );

  always #6 clk = ~clk;

  function automatic int gap_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Stall the token side at random, with quiet stretches
  initial begin
    int n;
    item_out.ready = 1'b0;
    forever begin
      n = gap_length();
      if (stall_sink && n > 0) begin
        item_out.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      item_out.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  // Send one octet, waiting for its beat
  task automatic send_octet(input logic [7:0] b, input logic last_octet);
    int n;
    n = gap_length();
    if (n > 0) begin
      pdu_in.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    pdu_in.valid    <= 1'b1;
    pdu_in.pdu_byte <= b;
    pdu_in.pdu_end  <= last_octet;
    @(posedge clk);
    while (!pdu_in.ready) @(posedge clk);
    octets_sent++;
  endtask

  task automatic send_pdu(input logic [7:0] pdu[$]);
    foreach (pdu[i]) send_octet(pdu[i], i == pdu.size() - 1);
  endtask

  // Build a deliver PDU with random content; some are cut short or extended
  function automatic void build_pdu(output logic [7:0] pdu[$], input int flavor);
    int smsc_len, snd_digits, udl, hdr_len, k;
    logic [7:0] b;
    pdu.delete();
    smsc_len = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 4);
    pdu = {pdu, 8'(smsc_len)};
    if (smsc_len > 0) begin
      pdu = {pdu, (($urandom_range(0, 3) == 0) ? 8'hD0
                                                : 8'(8'h81 | ($urandom_range(0, 1) << 4)))};
      for (int i = 1; i < smsc_len; i++) pdu = {pdu, 8'($urandom)};
    end
    pdu = {pdu, 8'(8'($urandom) & 8'hFC | (flavor[0] ? 8'h40 : 8'h00))};
    snd_digits = $urandom_range(0, 8);
    pdu = {pdu, 8'(snd_digits)};
    pdu = {pdu, (($urandom_range(0, 3) == 0) ? 8'hD0 : 8'($urandom))};
    for (int i = 0; i < (snd_digits + 1) / 2; i++) pdu = {pdu, 8'($urandom)};
    pdu = {pdu, 8'($urandom)};
    b = $urandom;
    pdu = {pdu, b};
    for (int i = 0; i < 7; i++) pdu = {pdu, 8'($urandom)};
    udl = $urandom_range(0, 12);
    pdu = {pdu, 8'(udl)};
    if (flavor[0]) begin
      hdr_len = $urandom_range(0, 3);
      case (hdr_len)
        1: begin
          pdu = {pdu, 8'd5, 8'h00, 8'd3};
          for (int i = 0; i < 3; i++) pdu = {pdu, 8'($urandom)};
        end
        2: begin
          pdu = {pdu, 8'd6, 8'h08, 8'd4};
          for (int i = 0; i < 4; i++) pdu = {pdu, 8'($urandom)};
        end
        3: begin
          k = $urandom_range(1, 6);
          pdu = {pdu, 8'(k)};
          for (int i = 0; i < k; i++)
            pdu = {pdu, (($urandom_range(0, 3) == 0) ? 8'(i) : 8'($urandom))};
        end
        default: pdu = {pdu, 8'd0};
      endcase
    end
    for (int i = 0; i < udl; i++) pdu = {pdu, 8'($urandom)};
    // cut or extend some
    if (flavor[2:1] == 2'b00 && pdu.size() > 2) begin
      k = $urandom_range(1, pdu.size() - 1);
      while (pdu.size() > k) void'(pdu.pop_back());
    end else if (flavor[2:1] == 2'b01) begin
      for (int i = 0; i < $urandom_range(1, 3); i++) pdu = {pdu, 8'($urandom)};
    end
  endfunction

  initial begin
    logic [7:0] pdu[$];
    pdu_in.valid    <= 1'b0;
    pdu_in.pdu_byte <= 8'h00;
    pdu_in.pdu_end  <= 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: international sender, header with 16-bit reference, UCS2
    stall_sink = 1'b0;
    pdu = '{8'h00, 8'h40, 8'h03, 8'h91, 8'h21, 8'hF3, 8'h00, 8'hE8,
            8'h10, 8'h20, 8'h30, 8'h40, 8'h50, 8'h60, 8'h8B, 8'h08,
            8'h07, 8'h08, 8'h04, 8'hAB, 8'hCD, 8'h03, 8'h02, 8'hFF};
    send_pdu(pdu);
    // Not a deliver message, then too short, then end right after timestamp
    send_pdu('{8'h00, 8'h03, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
               8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
    send_pdu('{8'h07, 8'hD1, 8'hFF});
    send_pdu('{8'h01, 8'h91, 8'h00, 8'h02, 8'hD0, 8'hC1, 8'h00, 8'hF4,
               8'h99, 8'h99, 8'h99, 8'h99, 8'h99, 8'h99, 8'hFF});

    stall_sink = 1'b1;
    while (octets_sent < 230) begin
      build_pdu(pdu, $urandom_range(0, 7));
      if ($urandom_range(0, 9) == 0) begin
        pdu.delete();
        for (int i = 0; i < $urandom_range(1, 30); i++) pdu = {pdu, 8'($urandom)};
      end
      send_pdu(pdu);
    end
    pdu_in.valid <= 1'b0;
    while (tokens_pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

`default_nettype wire

@@ filelist.f @@
src/smsdp_pkg.sv
src/smsdp_if.sv
src/smsdp_step.sv
src/sms_deliver_pdu_parser.sv
src/smsdp_chk.sv
test/sms_deliver_pdu_parser_checker.sv
test/sms_deliver_pdu_parser_test.sv
